FILE: rtl/core/tkf_pkg.sv
`timescale 1ns / 1ps
package tkf_pkg;
    localparam int TableDepthDefault = 1024;
    localparam int TopMaxDefault     = 16;
    localparam logic [4:0] TopCountReset = 5'd10;
    localparam logic CmdCount  = 1'b0;
    localparam logic CmdFinish = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SCAN_CHK,
        ST_WALK,
        ST_WALK_WAIT,
        ST_WALK_INS,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // Write request toward the table memory.
    typedef struct packed {
        logic        wr;
        logic [31:0] key;
        logic [31:0] count;
    } tbl_wr_t;
endpackage

FILE: rtl/core/tkf_table.sv
`timescale 1ns / 1ps
module tkf_table #(
    parameter int DEPTH = tkf_pkg::TableDepthDefault,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic [AW-1:0]        rd_addr,
    output logic [31:0]          rd_key,
    output logic [31:0]          rd_count,
    input  logic [AW-1:0]        wr_addr,
    input  tkf_pkg::tbl_wr_t     wr
);
    import tkf_pkg::*;

    logic [31:0] key_mem [DEPTH];
    logic [31:0] cnt_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.wr)
        begin
            key_mem[wr_addr] <= wr.key;
            cnt_mem[wr_addr] <= wr.count;
        end
        rd_key   <= key_mem[rd_addr];
        rd_count <= cnt_mem[rd_addr];
    end
endmodule

FILE: rtl/core/top_k_frequent_ids.sv
`timescale 1ns / 1ps
// Count item: linear search of the table, each entry checked passing through read, wait
// and compare states, and a new ID appended after the last one; one memory read port
// sets the pace. Finish item: the walk takes each stored entry through read, wait and
// insert states, then one result per cycle while m_axis_tready is high.
// No new item is taken while one is in work. Reset clears counters, flags and
// top_count (to 10); the table memories keep their contents, guarded by the fill count.
module top_k_frequent_ids #(
    parameter int TABLE_DEPTH = tkf_pkg::TableDepthDefault,
    parameter int TOP_MAX     = tkf_pkg::TopMaxDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // user_id
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // rank[3:0], top_id[35:4], occurrences[67:36], 0
    output logic [1:0]  m_axis_tuser,   // empty_res, overflow
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);
    import tkf_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = $clog2(TOP_MAX);
    localparam int KW = $clog2(TOP_MAX + 1);

    state_t state_reg, state_next;
    logic [4:0]    topc_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          drop_reg, drop_next;
    logic [31:0]   id_reg, id_next;
    logic [KW-1:0] filled_reg, filled_next;
    logic [KW-1:0] k_reg, k_next;
    logic [TW-1:0] pos_reg, pos_next;
    logic [31:0]   top_id_reg  [TOP_MAX];
    logic [31:0]   top_cnt_reg [TOP_MAX];

    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   rd_key, rd_count;
    tbl_wr_t       wr;

    tkf_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .clk(clk), .rd_addr(rd_addr), .rd_key(rd_key), .rd_count(rd_count),
        .wr_addr(wr_addr), .wr(wr)
    );

    // Insert position: number of list entries whose count is >= the new count.
    logic [KW-1:0] ins_pos;
    always_comb
    begin
        ins_pos = '0;
        for (int j = 0; j < TOP_MAX; j++)
            if (KW'(j) < filled_reg && top_cnt_reg[j] >= rd_count)
                ins_pos = ins_pos + 1'b1;
    end

    logic [4:0] kc;
    always_comb
    begin
        kc = topc_reg;
        if (kc == 5'd0) kc = 5'd1;
        if (32'(kc) > TOP_MAX) kc = 5'(TOP_MAX);
    end

    logic ins_do;
    assign ins_do = (ins_pos < k_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WALK_INS && ins_do)
        begin
            for (int j = 0; j < TOP_MAX; j++)
            begin
                if (KW'(j) == ins_pos)
                begin
                    top_id_reg[j]  <= rd_key;
                    top_cnt_reg[j] <= rd_count;
                end
                else if (KW'(j) > ins_pos && j > 0)
                begin
                    top_id_reg[j]  <= top_id_reg[j-1];
                    top_cnt_reg[j] <= top_cnt_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            topc_reg   <= TopCountReset;
            used_reg   <= '0;
            idx_reg    <= '0;
            drop_reg   <= 1'b0;
            id_reg     <= '0;
            filled_reg <= '0;
            k_reg      <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we) topc_reg <= cfg_wdata;
            used_reg   <= used_next;
            idx_reg    <= idx_next;
            drop_reg   <= drop_next;
            id_reg     <= id_next;
            filled_reg <= filled_next;
            k_reg      <= k_next;
            pos_reg    <= pos_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        idx_next    = idx_reg;
        drop_next   = drop_reg;
        id_next     = id_reg;
        filled_next = filled_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        rd_addr     = idx_reg[AW-1:0];
        wr_addr     = idx_reg[AW-1:0];
        wr          = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tdata  = '0;
        m_axis_tuser  = '0;
        m_axis_tlast  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    id_next  = s_axis_tdata;
                    idx_next = '0;
                    if (s_axis_tuser == CmdCount)
                        state_next = ST_SCAN;
                    else if (used_reg == '0)
                        state_next = ST_EMPTY;
                    else
                    begin
                        filled_next = '0;
                        k_next      = KW'(kc);
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == used_reg)
                begin
                    // Not found: append or flag a drop.
                    if (used_reg == CW'(TABLE_DEPTH))
                        drop_next = 1'b1;
                    else
                    begin
                        wr.wr     = 1'b1;
                        wr.key    = id_reg;
                        wr.count  = 32'd1;
                        used_next = used_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
                state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (rd_key == id_reg)
                begin
                    wr.wr    = 1'b1;
                    wr.key   = rd_key;
                    wr.count = (rd_count == '1) ? rd_count : rd_count + 32'd1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == used_reg)
                begin
                    pos_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_WALK_WAIT;
            end
            ST_WALK_WAIT:
                state_next = ST_WALK_INS;
            ST_WALK_INS:
            begin
                if (ins_do && filled_reg < k_reg)
                    filled_next = filled_reg + 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_WALK;
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata[3:0]   = 4'(pos_reg);
                m_axis_tdata[35:4]  = top_id_reg[pos_reg];
                m_axis_tdata[67:36] = top_cnt_reg[pos_reg];
                m_axis_tuser[1]     = drop_reg;
                m_axis_tlast = (KW'(pos_reg) + 1'b1 == filled_reg);
                if (m_axis_tready)
                begin
                    if (m_axis_tlast)
                    begin
                        used_next   = '0;
                        drop_next   = 1'b0;
                        filled_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            ST_EMPTY:
            begin
                m_axis_tvalid   = 1'b1;
                m_axis_tuser[0] = 1'b1;
                m_axis_tlast    = 1'b1;
                if (m_axis_tready)
                begin
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");
    assert property (@(posedge clk) disable iff (!rst_n) filled_reg <= KW'(TOP_MAX))
        else $error("top list overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (filled_reg != '0))
        else $error("emit with empty list");
endmodule

FILE: tb/tb_top_k_frequent_ids.sv
`timescale 1ns / 1ps
module tb_top_k_frequent_ids;
    import tkf_pkg::*;

    localparam int DEPTH     = 32;
    localparam int TOPN      = 16;
    localparam int LIMIT     = 400000;
    localparam int DRAIN_GAP = 3 * DEPTH + 40;

    typedef struct {
        logic [3:0]  rank;
        logic [31:0] top_id;
        logic [31:0] occurrences;
        logic        last;
        logic        empty_res;
        logic        overflow;
    } rank_entry_t;

    class freq_board;
        logic [31:0] ids[$];
        logic [31:0] hits[$];
        logic        dropped;
        logic [4:0]  top_cnt;
        rank_entry_t pending_q[$];
        int          errors;
        int          seen;
        int          finishes;
        int          overflows;

        function void clear_table();
            ids.delete();
            hits.delete();
            dropped = 1'b0;
        endfunction

        function void set_top(logic [4:0] v);
            top_cnt = v;
        endfunction

        function void note_item(logic cmd, logic [31:0] id);
            int          k;
            int          pos;
            int          filled;
            bit          found;
            logic [31:0] best_id[TOPN];
            logic [31:0] best_cnt[TOPN];
            rank_entry_t e;
            found = 0;
            filled = 0;
            if (cmd == CmdCount) begin
                foreach (ids[i]) begin
                    if (!found && ids[i] == id) begin
                        if (hits[i] != 32'hFFFF_FFFF)
                            hits[i]++;
                        found = 1;
                    end
                end
                if (!found) begin
                    if (ids.size() < DEPTH) begin
                        ids.push_back(id);
                        hits.push_back(32'd1);
                    end else
                        dropped = 1'b1;
                end
                return;
            end
            finishes++;
            if (ids.size() == 0) begin
                e = '{4'd0, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0};
                pending_q.push_back(e);
                clear_table();
                return;
            end
            k = (top_cnt == 0) ? 1 : (top_cnt > TOPN) ? TOPN : top_cnt;
            // insertion walk; a later entry moves up only on a strictly larger count
            foreach (ids[i]) begin
                pos = filled;
                while (pos > 0 && hits[i] > best_cnt[pos-1])
                    pos--;
                if (pos < k) begin
                    if (filled < k)
                        filled++;
                    for (int j = filled - 1; j > pos; j--) begin
                        best_id[j] = best_id[j-1];
                        best_cnt[j] = best_cnt[j-1];
                    end
                    best_id[pos] = ids[i];
                    best_cnt[pos] = hits[i];
                end
            end
            if (dropped)
                overflows++;
            for (int r = 0; r < filled; r++) begin
                e = '{r[3:0], best_id[r], best_cnt[r], (r == filled - 1), 1'b0, dropped};
                pending_q.push_back(e);
            end
            clear_table();
        endfunction

        function void check_result(rank_entry_t got);
            rank_entry_t w;
            seen++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result rank=%0d id=%h cnt=%0d", $time,
                         got.rank, got.top_id, got.occurrences);
                errors++;
                return;
            end
            w = pending_q.pop_front();
            if (got.rank !== w.rank || got.top_id !== w.top_id ||
                got.occurrences !== w.occurrences || got.last !== w.last ||
                got.empty_res !== w.empty_res || got.overflow !== w.overflow) begin
                $display("%0t: expected rank=%0d id=%h cnt=%0d last=%b empty=%b ovf=%b",
                         $time, w.rank, w.top_id, w.occurrences, w.last, w.empty_res,
                         w.overflow);
                $display("%0t: actual   rank=%0d id=%h cnt=%0d last=%b empty=%b ovf=%b",
                         $time, got.rank, got.top_id, got.occurrences, got.last,
                         got.empty_res, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;      // rank, top_id, occurrences, zero fill
    logic [1:0]  m_axis_tuser;      // empty_res, overflow
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    freq_board   board = new();
    int          cycles = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_tick = 0;
    int          burst_left = 0;
    int          items_sent = 0;
    logic [31:0] pool[64];

    always #1 clk = ~clk;

    top_k_frequent_ids #(.TABLE_DEPTH(DEPTH), .TOP_MAX(TOPN)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("top_k_frequent_ids: mismatch");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a mode-driven stall pattern
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_tick % 64 == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= (rx_tick % 5) >= 2;
                2: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= (rx_tick % 13) < 3;
            endcase
        end
    end

    always @(posedge clk)
    begin
        rank_entry_t got;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.rank = m_axis_tdata[3:0];
                got.top_id = m_axis_tdata[35:4];
                got.occurrences = m_axis_tdata[67:36];
                got.last = m_axis_tlast;
                got.empty_res = m_axis_tuser[0];
                got.overflow = m_axis_tuser[1];
                board.check_result(got);
            end
        end
    end

    // offer one item; keep tvalid high into the next item unless a gap follows
    task automatic push_item(logic cmd, logic [31:0] id);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= id;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_top(logic [4:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_top(v);
    endtask

    initial
    begin
        logic [4:0] tops[7] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd3};
        int         psize;
        logic [31:0] a;
        logic [31:0] b;
        board.clear_table();
        board.set_top(TopCountReset);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // finish on an empty table, extreme IDs, equal counts keep first-seen order
        a = $urandom;
        b = ~a;
        push_item(CmdFinish, 32'hFFFF_FFFF);
        push_item(CmdCount, 32'h0000_0000);
        push_item(CmdCount, 32'hFFFF_FFFF);
        push_item(CmdCount, 32'h0000_0000);
        push_item(CmdCount, a);
        push_item(CmdCount, b);
        push_item(CmdCount, b);
        push_item(CmdCount, a);
        push_item(CmdCount, 32'hFFFF_FFFF);
        push_item(CmdCount, 32'h8000_0001);
        push_item(CmdFinish, 32'd0);
        push_item(CmdFinish, 32'd0);
        drain();

        for (int p = 0; p < 7; p++) begin
            write_top(tops[p]);
            psize = (p == 3 || p == 5) ? 48 : $urandom_range(2, 20);
            foreach (pool[i])
                pool[i] = $urandom;
            if (p == 2)
                hold_req++;
            for (int i = 0; i < 40; i++) begin
                if ((p == 2 && i == 3) || $urandom_range(0, 14) == 0)
                    push_item(CmdFinish, $urandom);
                else if ($urandom_range(0, 9) == 0)
                    push_item(CmdCount, $urandom);
                else
                    push_item(CmdCount, pool[$urandom_range(0, psize - 1)]);
            end
            push_item(CmdFinish, $urandom);
            drain();
        end

        $display("ran %0d items, %0d finish runs (%0d with table overflow), %0d results",
                 items_sent, board.finishes, board.overflows, board.seen);
        $display("top_count settings covered 0, 1, 3, 5, 10, 16, 17 and 31");
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("top_k_frequent_ids: match");
        else
            $display("top_k_frequent_ids: mismatch");
        $finish;
    end
endmodule

FILE: top_k_frequent_ids.f
rtl/core/tkf_pkg.sv
rtl/core/tkf_table.sv
rtl/core/top_k_frequent_ids.sv
tb/tb_top_k_frequent_ids.sv
